### sv/npc_pkg.sv
// Package for the nearest palette colour search.
// Field widths, function codes and limits shared by the interfaces and the top level.
// No dependencies.
`default_nettype none

package npc_pkg;

    localparam int COLOUR_W   = 8;
    localparam int INDEX_W    = 8;
    localparam int DIST_W     = 18;
    localparam int SQ_W       = 2 * COLOUR_W;
    localparam int SMALL_SIZE = 8;

    // largest possible squared distance: three components of 255 each
    localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [COLOUR_W-1:0] t_colour;
    typedef logic [SQ_W-1:0]     t_square;
    typedef logic [DIST_W-1:0]   t_dist;

    // square of the absolute difference of two colour components
    function automatic t_square sq_diff(input t_colour a, input t_colour b);
        t_colour d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

`default_nettype wire

### sv/npc_if.sv
// Handshake channels of the nearest palette colour search: request, response, configuration.
// Depends on npc_pkg for the field widths.
`default_nettype none

interface npc_req_if import npc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [INDEX_W-1:0]  entry_index;
    t_colour             red;
    t_colour             green;
    t_colour             blue;

    modport source(output valid, func, entry_index, red, green, blue, input ready);
    modport sink(input valid, func, entry_index, red, green, blue, output ready);
endinterface

interface npc_rsp_if import npc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  nearest_index;
    t_dist               best_distance;

    modport source(output valid, nearest_index, best_distance, input ready);
    modport sink(input valid, nearest_index, best_distance, output ready);
endinterface

interface npc_cfg_if ();
    logic valid;
    logic ready;
    logic data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

### sv/npc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### sv/nearest_palette_color.sv
// Top level of the nearest palette colour search: palette RAM, scan sequencer,
// distance pipeline and result register. Depends on npc_pkg, npc_if.sv and npc_ram.
//
//  channel  | dir | transaction                                  | fields
//  ---------+-----+----------------------------------------------+---------------------------
//  i_req    | in  | palette write (func 0) or query (func 1)     | func entry_index red green blue
//  o_rsp    | out | one result per query, none per write         | nearest_index best_distance
//  i_cfg    | in  | write of use_small_palette                   | data
//
// A query scans N entries, N being 8 with the small palette (PALETTE_DEPTH if that is less)
// and PALETTE_DEPTH otherwise: the single RAM read port delivers one entry a cycle into the
// registered read, the squares, the sum and the compare against the running best.
// Requests are refused until a query's result is loaded; a finished result waits in the output
// register while the next request is taken, and a second result waits in the done state.
// Reset is synchronous and active low; the palette is not cleared by reset.
`default_nettype none

module nearest_palette_color import npc_pkg::*; #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    npc_req_if.sink   i_req,
    npc_rsp_if.source o_rsp,
    npc_cfg_if.sink   i_cfg
);

    localparam int AW           = $clog2(PALETTE_DEPTH);
    localparam int ENTRY_W      = 3 * COLOUR_W;
    localparam int ACTIVE_SMALL = (SMALL_SIZE < PALETTE_DEPTH) ? SMALL_SIZE : PALETTE_DEPTH;
    localparam logic [AW-1:0] LAST_FULL  = AW'(PALETTE_DEPTH - 1);
    localparam logic [AW-1:0] LAST_SMALL = AW'(ACTIVE_SMALL - 1);
    localparam logic [INDEX_W:0] DEPTH_LIMIT = (INDEX_W + 1)'(PALETTE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [AW-1:0]      r_scan_addr, n_scan_addr;
    logic               r_small;
    logic               req_acc, wr_acc, qry_acc, rd_en, ram_we, out_load;
    logic [AW-1:0]      last_addr;
    logic [ENTRY_W-1:0] ram_rdata;

    // query colour
    t_colour            r_qr, r_qg, r_qb;

    // pipeline: RAM output, squares, sum
    logic               r_v0, r_v1, r_v2;
    logic               r_last0, r_last1, r_last2;
    logic [AW-1:0]      r_i0, r_i1, r_i2;
    t_square            r_sq_r, r_sq_g, r_sq_b;
    t_dist              r_dist2;

    // running best and result register
    logic [AW-1:0]      r_best_i;
    t_dist              r_best_d;
    logic               r_out_valid;
    logic [AW-1:0]      r_out_idx;
    t_dist              r_out_dist;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign wr_acc      = req_acc && (i_req.func == FUNC_WRITE);
    assign qry_acc     = req_acc && (i_req.func == FUNC_QUERY);
    assign ram_we      = wr_acc && ({1'b0, i_req.entry_index} < DEPTH_LIMIT);
    assign rd_en       = (r_state == S_SCAN);
    assign last_addr   = r_small ? LAST_SMALL : LAST_FULL;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    npc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.entry_index[AW-1:0]),
        .i_wdata ({i_req.red, i_req.green, i_req.blue}),
        .i_re    (rd_en),
        .i_raddr (r_scan_addr),
        .o_rdata (ram_rdata)
    );

    // sequence the scan
    always_comb begin
        n_state     = r_state;
        n_scan_addr = r_scan_addr;
        unique case (r_state)
            S_IDLE: begin
                if (qry_acc) begin
                    n_state     = S_SCAN;
                    n_scan_addr = '0;
                end
            end
            S_SCAN: begin
                if (r_scan_addr == last_addr) begin
                    n_state = S_DRAIN;
                end else begin
                    n_scan_addr = r_scan_addr + AW'(1);
                end
            end
            S_DRAIN: begin
                if (r_v2 && r_last2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_addr <= '0;
            r_small     <= 1'b0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_addr <= n_scan_addr;
            r_v0        <= rd_en;
            r_v1        <= r_v0;
            r_v2        <= r_v1;
            if (i_cfg.valid && i_cfg.ready) begin
                r_small <= i_cfg.data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latch the query colour
    always_ff @(posedge i_clk) begin
        if (qry_acc) begin
            r_qr <= i_req.red;
            r_qg <= i_req.green;
            r_qb <= i_req.blue;
        end
    end

    // advance the distance pipeline
    always_ff @(posedge i_clk) begin
        r_i0    <= r_scan_addr;
        r_last0 <= (r_scan_addr == last_addr);
        r_i1    <= r_i0;
        r_last1 <= r_last0;
        r_sq_r  <= sq_diff(r_qr, ram_rdata[3*COLOUR_W-1:2*COLOUR_W]);
        r_sq_g  <= sq_diff(r_qg, ram_rdata[2*COLOUR_W-1:COLOUR_W]);
        r_sq_b  <= sq_diff(r_qb, ram_rdata[COLOUR_W-1:0]);
        r_i2    <= r_i1;
        r_last2 <= r_last1;
        r_dist2 <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
    end

    // keep the best entry: the first always, later ones only when strictly closer
    always_ff @(posedge i_clk) begin
        if (r_v2 && ((r_i2 == '0) || (r_dist2 < r_best_d))) begin
            r_best_i <= r_i2;
            r_best_d <= r_dist2;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx  <= r_best_i;
            r_out_dist <= r_best_d;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.nearest_index = INDEX_W'(r_out_idx);
    assign o_rsp.best_distance = r_out_dist;

    // palette writes never overlap a scan in flight
    a_no_write_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !(r_v0 || r_v1 || r_v2 || rd_en))
        else $error("palette written while a scan is in flight");

    // an accepted query starts the scan at entry zero
    a_scan_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qry_acc |=> (r_state == S_SCAN) && (r_scan_addr == '0))
        else $error("query did not start its scan at entry zero");

    // the last compare closes the query
    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_last2) |=> (r_state == S_DONE))
        else $error("last entry compared without finishing the query");

    // a shown distance is within the range of three squared components
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.best_distance <= MAX_DIST))
        else $error("distance out of range");

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for nearest_palette_color: directed table, then random palette traffic.
// Depends on npc_pkg, the channel interfaces in npc_if.sv and the top level.
// Results are checked in order against the table or a behavioural search of a shadow palette.
`default_nettype none

module testbench;
    import npc_pkg::*;

    localparam int          PALETTE_DEPTH = 256;
    localparam int unsigned SETTLE_CYCLES = PALETTE_DEPTH + 8;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned HOLD_CYCLES   = 2000;
    localparam int unsigned PHASE_ITEMS   = 155;
    localparam int unsigned PHASE_COUNT   = 6;

    typedef struct packed {
        t_colour red;
        t_colour green;
        t_colour blue;
    } t_rgb;

    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] entry_index;
        t_colour            red;
        t_colour            green;
        t_colour            blue;
    } t_colour_req;

    typedef struct packed {
        logic [INDEX_W-1:0] nearest_index;
        t_dist              best_distance;
    } t_match;

    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] entry_index;
        t_colour            red;
        t_colour            green;
        t_colour            blue;
        logic               typed;
        logic [INDEX_W-1:0] want_index;
        t_dist              want_distance;
    } t_directed_row;

    // Small palette is selected before this table is walked; only entries 0..7 are searched.
    localparam t_directed_row DIRECTED_ROWS [25] = '{
        '{FUNC_WRITE, 8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd1,   8'hFF, 8'hFF, 8'hFF, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd2,   8'hFF, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd3,   8'h00, 8'hFF, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd4,   8'h00, 8'h00, 8'hFF, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd5,   8'h80, 8'h80, 8'h80, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd6,   8'h80, 8'h80, 8'h80, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd7,   8'h01, 8'h02, 8'h03, 1'b0, 8'd0, 18'd0},
        // top entry index, outside the small palette
        '{FUNC_WRITE, 8'd255, 8'h12, 8'h34, 8'h56, 1'b0, 8'd0, 18'd0},
        '{FUNC_QUERY, 8'hFF,  8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd1, 18'd0},
        '{FUNC_QUERY, 8'h00,  8'h00, 8'h00, 8'h00, 1'b1, 8'd0, 18'd0},
        // tie between entries 5 and 6: lower index stays
        '{FUNC_QUERY, 8'h00,  8'h80, 8'h80, 8'h80, 1'b1, 8'd5, 18'd0},
        '{FUNC_QUERY, 8'h00,  8'h81, 8'h80, 8'h80, 1'b1, 8'd5, 18'd1},
        '{FUNC_QUERY, 8'h00,  8'hFF, 8'h00, 8'h00, 1'b1, 8'd2, 18'd0},
        '{FUNC_QUERY, 8'h00,  8'h01, 8'h02, 8'h03, 1'b1, 8'd7, 18'd0},
        '{FUNC_QUERY, 8'h00,  8'h7F, 8'h80, 8'h80, 1'b1, 8'd5, 18'd1},
        '{FUNC_QUERY, 8'h5A,  8'h40, 8'hC0, 8'h20, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd1,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd2,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd3,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd4,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd5,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd6,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        '{FUNC_WRITE, 8'd7,   8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 18'd0},
        // all-black palette against white: largest distance
        '{FUNC_QUERY, 8'h00,  8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd0, 18'd195075}
    };

    logic i_clk;
    logic i_rst_n;

    npc_req_if req_ch ();
    npc_rsp_if rsp_ch ();
    npc_cfg_if cfg_ch ();

    nearest_palette_color #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    t_rgb        shadow_palette [PALETTE_DEPTH];
    bit          small_active;
    t_match      pending_matches [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned hold_seq;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Search the active part of the shadow palette; lowest index keeps a tie
    function automatic t_match closest_entry(input t_colour r, input t_colour g, input t_colour b);
        t_match      best;
        int unsigned span;
        int unsigned sq_dist;
        int          dr;
        int          dg;
        int          db;
        span = small_active ? SMALL_SIZE : PALETTE_DEPTH;
        if (span > PALETTE_DEPTH) span = PALETTE_DEPTH;
        best = '0;
        for (int unsigned k = 0; k < span; k++) begin
            dr = int'(r) - int'(shadow_palette[k].red);
            dg = int'(g) - int'(shadow_palette[k].green);
            db = int'(b) - int'(shadow_palette[k].blue);
            sq_dist = int'(dr * dr + dg * dg + db * db);
            if (k == 0 || sq_dist < best.best_distance) begin
                best.best_distance = t_dist'(sq_dist);
                best.nearest_index = INDEX_W'(k);
            end
        end
        return best;
    endfunction

    // Move a component a few steps off, clamped to the colour range
    function automatic t_colour nudge(input t_colour c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return t_colour'(v);
    endfunction

    function automatic t_colour_req random_request();
        t_colour_req item;
        t_rgb        base;
        int unsigned span;
        int unsigned pick;
        span = small_active ? SMALL_SIZE : PALETTE_DEPTH;
        item.entry_index = INDEX_W'($urandom_range(255));
        item.red   = t_colour'($urandom_range(255));
        item.green = t_colour'($urandom_range(255));
        item.blue  = t_colour'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 35) begin
            item.func = FUNC_WRITE;
            // aim writes at the searched entries when the palette is small
            if (small_active && $urandom_range(1) == 0)
                item.entry_index = INDEX_W'($urandom_range(SMALL_SIZE - 1));
            // duplicate an existing colour now and then to provoke ties
            if ($urandom_range(3) == 0) begin
                base = shadow_palette[$urandom_range(span - 1)];
                item.red   = base.red;
                item.green = base.green;
                item.blue  = base.blue;
            end
        end else begin
            item.func = FUNC_QUERY;
            if (pick < 70) begin
                base = shadow_palette[$urandom_range(span - 1)];
                item.red   = nudge(base.red);
                item.green = nudge(base.green);
                item.blue  = nudge(base.blue);
            end else if (pick < 80) begin
                item.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                item.green = $urandom_range(1) ? 8'hFF : 8'h00;
                item.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
        end
        return item;
    endfunction

    // Offer one request, hold it until accepted, then update the shadow state
    task automatic issue_request(input t_colour_req item, input bit typed, input t_match want);
        t_match predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= item.func;
        req_ch.entry_index <= item.entry_index;
        req_ch.red         <= item.red;
        req_ch.green       <= item.green;
        req_ch.blue        <= item.blue;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        if (item.func == FUNC_WRITE) begin
            shadow_palette[item.entry_index] = '{item.red, item.green, item.blue};
        end else begin
            if (typed)
                predicted = want;
            else
                predicted = closest_entry(item.red, item.green, item.blue);
            pending_matches = {pending_matches, predicted};
        end
    endtask

    // Drop valid, wait for every result, then let any trailing write drain
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_palette_size(input bit use_small);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= use_small;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        small_active = use_small;
    endtask

    // Response side: random stalls, long hold-off on request, in-order check
    always @(posedge i_clk) begin : response_check
        t_match want;
        if (hold_seen != hold_seq) begin
            hold_seen    <= hold_seq;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_matches.size() == 0) begin
                report_mismatch($sformatf("unexpected result index %0d distance %0d",
                                          rsp_ch.nearest_index, rsp_ch.best_distance));
            end else begin
                want = pending_matches.pop_front();
                if (rsp_ch.nearest_index !== want.nearest_index)
                    report_mismatch($sformatf("nearest_index %0d, expected %0d",
                                              rsp_ch.nearest_index, want.nearest_index));
                if (rsp_ch.best_distance !== want.best_distance)
                    report_mismatch($sformatf("best_distance %0d, expected %0d",
                                              rsp_ch.best_distance, want.best_distance));
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        t_colour_req item;
        t_match      want;
        i_rst_n            = 1'b0;
        hold_seq           = 0;
        small_active       = 1'b0;
        send_idle_pct      = 23;
        rcv_idle_pct       <= 74;
        req_ch.valid       <= 1'b0;
        req_ch.func        <= FUNC_WRITE;
        req_ch.entry_index <= '0;
        req_ch.red         <= '0;
        req_ch.green       <= '0;
        req_ch.blue        <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= 1'b0;
        for (int k = 0; k < PALETTE_DEPTH; k++) shadow_palette[k] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table on the small palette
        write_palette_size(1'b1);
        foreach (DIRECTED_ROWS[n]) begin
            item.func          = DIRECTED_ROWS[n].func;
            item.entry_index   = DIRECTED_ROWS[n].entry_index;
            item.red           = DIRECTED_ROWS[n].red;
            item.green         = DIRECTED_ROWS[n].green;
            item.blue          = DIRECTED_ROWS[n].blue;
            want.nearest_index = DIRECTED_ROWS[n].want_index;
            want.best_distance = DIRECTED_ROWS[n].want_distance;
            issue_request(item, DIRECTED_ROWS[n].typed, want);
        end
        settle_block();

        // Load every entry so the full palette can be searched
        write_palette_size(1'b0);
        for (int k = 0; k < PALETTE_DEPTH; k++) begin
            item.func        = FUNC_WRITE;
            item.entry_index = INDEX_W'(k);
            item.red         = t_colour'($urandom_range(255));
            item.green       = t_colour'($urandom_range(255));
            item.blue        = t_colour'($urandom_range(255));
            issue_request(item, 1'b0, '0);
        end
        settle_block();

        // Random phases: idle pattern changes every two phases, size alternates
        want = '0;
        for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
            write_palette_size(phase % 2 == 0);
            unique case (phase / 2)
                0: begin
                    send_idle_pct = 23;
                    rcv_idle_pct  <= 74;
                end
                1: begin
                    send_idle_pct = 74;
                    rcv_idle_pct  <= 23;
                end
                default: begin
                    send_idle_pct = 0;
                    rcv_idle_pct  <= 0;
                end
            endcase
            // hold the response side off while requests keep coming
            if (phase == 4) hold_seq <= hold_seq + 1;
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
                issue_request(random_request(), 1'b0, want);
            settle_block();
        end

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
